// File: rtl/core/gdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_pkg
// Shared types and fixed field widths of the graph degree correlation block.
// ----------------------------------------------------------------------------
package gdc_pkg;

  localparam int ID_W  = 11;
  localparam int ROW_W = 10;
  localparam int AVG_W = 20;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_FULL         = 3'd1,
    ST_BAD_ID       = 3'd2,
    ST_ROW_RANGE    = 3'd3,
    ST_NOT_COMPUTED = 3'd4
  } status_e;

  typedef struct packed {
    mode_e             mode;
    logic [ID_W-1:0]   source_node;
    logic [ID_W-1:0]   target_node;
    logic [ROW_W-1:0]  degree_row;
  } gdc_in_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   node_total;
    logic [ID_W-1:0]   in_degree_count;
    logic [ID_W-1:0]   out_degree_count;
    logic [AVG_W-1:0]  avg_pred_in_degree;
    logic [AVG_W-1:0]  avg_pred_out_degree;
    logic [AVG_W-1:0]  avg_succ_in_degree;
    logic [AVG_W-1:0]  avg_succ_out_degree;
    logic              degree_saturated;
  } gdc_out_t;

endpackage
`default_nettype wire

// File: rtl/core/gdc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/core/gdc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gdc_div #(
  parameter int DVD_W = 34,
  parameter int DVS_W = 13
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], fits};
      rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// File: rtl/core/graph_degree_correlation.sv
`timescale 1ns / 1ps
`default_nettype none
// Clear and add-edge transactions: the result is registered through the response state, one at a time.
// Finish: read-modify-write passes over the degree and bin memories: clear the nodes,
//   count degrees over the edges, bin the nodes, then sum neighbor degrees over the edges.
// Read row: the four averages are computed in turn on the shared divider; an empty bin gives zero.
// Reset clears the edge count, node count and flags; the degree and bin memories are cleared by finish.
// ----------------------------------------------------------------------------
// graph_degree_correlation
// Directed degree histograms and average neighbor degree per degree bin.
// ----------------------------------------------------------------------------
module graph_degree_correlation #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096,
  parameter int FRAC_BITS = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire gdc_pkg::gdc_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output gdc_pkg::gdc_out_t     out_data_o
);

  localparam int ID_W  = gdc_pkg::ID_W;
  localparam int AVG_W = gdc_pkg::AVG_W;
  localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW   = $clog2(MAX_EDGES + 1);
  localparam int NAW   = $clog2(MAX_NODES);
  localparam int DW    = ECW;
  localparam int SW    = 2 * DW;
  localparam int HW    = ID_W;
  localparam int RW    = HW + DW + 2 * SW;
  localparam int QW    = SW + FRAC_BITS;
  localparam int EW    = 2 * ID_W;

  typedef enum logic [4:0] {
    S_IDLE, S_RESP, S_CLR,
    S_E1_RD, S_E1_DEG, S_E1_INC,
    S_N_RD, S_N_ST, S_N_WR,
    S_E2_RD, S_E2_SRC, S_E2_DST, S_E2_ST, S_E2_WR,
    S_R_RD, S_R_LAT, S_R_GO, S_R_WAIT
  } state_e;

  state_e              state_q;
  logic [ECW-1:0]      edge_total_q;
  logic [ID_W-1:0]     largest_q;
  logic                computed_q;
  logic                sat_q;
  gdc_pkg::status_e    status_q;
  logic                rd_ok_q;
  logic [ID_W-1:0]     nidx_q;
  logic [ECW-1:0]      eidx_q;
  logic [ID_W-1:0]     src_q;
  logic [ID_W-1:0]     dst_q;
  logic [DW-1:0]       sin_q;
  logic [DW-1:0]       sout_q;
  logic [DW-1:0]       tin_q;
  logic [DW-1:0]       tout_q;
  logic [NAW-1:0]      bi_q;
  logic [NAW-1:0]      bo_q;
  logic [NAW-1:0]      row_q;
  logic [RW-1:0]       pred_q;
  logic [RW-1:0]       succ_q;
  logic [1:0]          k_q;
  logic [AVG_W-1:0]    avg_q [4];
  logic                out_valid_q;
  gdc_pkg::gdc_out_t   out_q;

  logic                in_fire;
  logic                out_free;
  logic [ID_W-1:0]     n_m1;
  logic                id_bad;
  logic                list_full;
  logic                row_bad;

  logic                edge_we;
  logic [EAW-1:0]      edge_waddr;
  logic [EW-1:0]       edge_wdata;
  logic [EAW-1:0]      edge_raddr;
  logic [EW-1:0]       edge_rd;
  logic [ID_W-1:0]     edge_src;
  logic [ID_W-1:0]     edge_dst;

  logic                deg_we;
  logic [NAW-1:0]      in_waddr;
  logic [NAW-1:0]      out_waddr;
  logic [DW-1:0]       in_wdata;
  logic [DW-1:0]       out_wdata;
  logic [NAW-1:0]      in_raddr;
  logic [NAW-1:0]      out_raddr;
  logic [DW-1:0]       in_rd;
  logic [DW-1:0]       out_rd;

  logic                st_we;
  logic [NAW-1:0]      pred_waddr;
  logic [NAW-1:0]      succ_waddr;
  logic [RW-1:0]       pred_wdata;
  logic [RW-1:0]       succ_wdata;
  logic [NAW-1:0]      pred_raddr;
  logic [NAW-1:0]      succ_raddr;
  logic [RW-1:0]       pred_rd;
  logic [RW-1:0]       succ_rd;

  logic [RW-1:0]       sel_row;
  logic [SW-1:0]       sel_sum;
  logic [DW-1:0]       sel_cnt;
  logic                div_start;
  logic                div_done;
  logic [QW-1:0]       div_quo;
  logic [AVG_W-1:0]    div_avg;

  function automatic logic [NAW-1:0] bin_of(input logic [DW-1:0] deg,
                                            input logic [ID_W-1:0] n);
    logic [31:0] v;
    v = (32'(deg) >= 32'(n)) ? (32'(n) - 32'd1) : 32'(deg);
    return NAW'(v);
  endfunction

  function automatic logic [RW-1:0] row_add(input logic [RW-1:0] r,
                                            input logic [DW-1:0] a,
                                            input logic [DW-1:0] b);
    logic [RW-1:0] o;
    o = r;
    o[SW-1:0]           = r[SW-1:0] + SW'(a);
    o[2*SW-1:SW]        = r[2*SW-1:SW] + SW'(b);
    o[2*SW+DW-1:2*SW]   = r[2*SW+DW-1:2*SW] + DW'(1);
    return o;
  endfunction

  function automatic logic [RW-1:0] row_hist(input logic [RW-1:0] r);
    logic [RW-1:0] o;
    o = r;
    o[RW-1:2*SW+DW] = r[RW-1:2*SW+DW] + HW'(1);
    return o;
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign n_m1       = largest_q - ID_W'(1);
  assign edge_src   = edge_rd[EW-1:ID_W];
  assign edge_dst   = edge_rd[ID_W-1:0];

  assign id_bad    = (in_data_i.source_node == '0) || (in_data_i.target_node == '0) ||
                     (32'(in_data_i.source_node) > MAX_NODES) ||
                     (32'(in_data_i.target_node) > MAX_NODES);
  assign list_full = (32'(edge_total_q) >= MAX_EDGES);
  assign row_bad   = (ID_W'(in_data_i.degree_row) >= largest_q) ||
                     (32'(in_data_i.degree_row) >= MAX_NODES);

  always_comb begin
    edge_we    = 1'b0;
    edge_waddr = EAW'(edge_total_q);
    edge_wdata = {in_data_i.source_node, in_data_i.target_node};
    edge_raddr = EAW'(eidx_q);
    deg_we     = 1'b0;
    in_waddr   = NAW'(nidx_q);
    out_waddr  = NAW'(nidx_q);
    in_wdata   = '0;
    out_wdata  = '0;
    in_raddr   = NAW'(nidx_q);
    out_raddr  = NAW'(nidx_q);
    st_we      = 1'b0;
    pred_waddr = NAW'(nidx_q);
    succ_waddr = NAW'(nidx_q);
    pred_wdata = '0;
    succ_wdata = '0;
    pred_raddr = row_q;
    succ_raddr = row_q;
    case (state_q)
      S_IDLE: begin
        edge_we = in_fire && (in_data_i.mode == gdc_pkg::MODE_ADD) && !id_bad && !list_full;
      end
      S_CLR: begin
        deg_we = 1'b1;
        st_we  = 1'b1;
      end
      S_E1_DEG: begin
        out_raddr = NAW'(edge_src - ID_W'(1));
        in_raddr  = NAW'(edge_dst - ID_W'(1));
      end
      S_E1_INC: begin
        deg_we    = 1'b1;
        out_waddr = NAW'(src_q - ID_W'(1));
        in_waddr  = NAW'(dst_q - ID_W'(1));
        out_wdata = out_rd + DW'(1);
        in_wdata  = in_rd + DW'(1);
      end
      S_N_ST: begin
        pred_raddr = bin_of(in_rd, largest_q);
        succ_raddr = bin_of(out_rd, largest_q);
      end
      S_N_WR: begin
        st_we      = 1'b1;
        pred_waddr = bi_q;
        succ_waddr = bo_q;
        pred_wdata = row_hist(pred_rd);
        succ_wdata = row_hist(succ_rd);
      end
      S_E2_SRC: begin
        in_raddr  = NAW'(edge_src - ID_W'(1));
        out_raddr = NAW'(edge_src - ID_W'(1));
      end
      S_E2_DST: begin
        in_raddr  = NAW'(dst_q - ID_W'(1));
        out_raddr = NAW'(dst_q - ID_W'(1));
      end
      S_E2_ST: begin
        pred_raddr = bin_of(in_rd, largest_q);
        succ_raddr = bin_of(sout_q, largest_q);
      end
      S_E2_WR: begin
        st_we      = 1'b1;
        pred_waddr = bi_q;
        succ_waddr = bo_q;
        pred_wdata = row_add(pred_rd, sin_q, sout_q);
        succ_wdata = row_add(succ_rd, tin_q, tout_q);
      end
      default: begin
      end
    endcase
  end

  assign sel_row   = k_q[1] ? succ_q : pred_q;
  assign sel_sum   = k_q[0] ? sel_row[2*SW-1:SW] : sel_row[SW-1:0];
  assign sel_cnt   = sel_row[2*SW+DW-1:2*SW];
  assign div_start = (state_q == S_R_GO) && (sel_cnt != '0);
  assign div_avg   = ((div_quo >> AVG_W) != '0) ? {AVG_W{1'b1}} : AVG_W'(div_quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      edge_total_q <= '0;
      largest_q    <= '0;
      computed_q   <= 1'b0;
      sat_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      status_q     <= gdc_pkg::ST_OK;
      rd_ok_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            status_q <= gdc_pkg::ST_OK;
            rd_ok_q  <= 1'b0;
            state_q  <= S_RESP;
            case (in_data_i.mode)
              gdc_pkg::MODE_CLEAR: begin
                edge_total_q <= '0;
                largest_q    <= '0;
                computed_q   <= 1'b0;
                sat_q        <= 1'b0;
              end
              gdc_pkg::MODE_ADD: begin
                if (id_bad) begin
                  status_q <= gdc_pkg::ST_BAD_ID;
                end else if (list_full) begin
                  status_q <= gdc_pkg::ST_FULL;
                end else begin
                  edge_total_q <= edge_total_q + ECW'(1);
                  largest_q    <= (in_data_i.source_node > in_data_i.target_node) ?
                                  ((in_data_i.source_node > largest_q) ?
                                   in_data_i.source_node : largest_q) :
                                  ((in_data_i.target_node > largest_q) ?
                                   in_data_i.target_node : largest_q);
                  computed_q   <= 1'b0;
                end
              end
              gdc_pkg::MODE_FINISH: begin
                computed_q <= 1'b1;
                sat_q      <= 1'b0;
                nidx_q     <= '0;
                if (largest_q != '0) begin
                  state_q <= S_CLR;
                end
              end
              default: begin
                row_q <= NAW'(in_data_i.degree_row);
                if (!computed_q) begin
                  status_q <= gdc_pkg::ST_NOT_COMPUTED;
                end else if (row_bad) begin
                  status_q <= gdc_pkg::ST_ROW_RANGE;
                end else begin
                  rd_ok_q <= 1'b1;
                  state_q <= S_R_RD;
                end
              end
            endcase
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_q                 <= 1'b1;
            out_q.status                <= status_q;
            out_q.node_total            <= largest_q;
            out_q.degree_saturated      <= sat_q;
            out_q.in_degree_count       <= rd_ok_q ? pred_q[RW-1:2*SW+DW] : '0;
            out_q.out_degree_count      <= rd_ok_q ? succ_q[RW-1:2*SW+DW] : '0;
            out_q.avg_pred_in_degree    <= rd_ok_q ? avg_q[0] : '0;
            out_q.avg_pred_out_degree   <= rd_ok_q ? avg_q[1] : '0;
            out_q.avg_succ_in_degree    <= rd_ok_q ? avg_q[2] : '0;
            out_q.avg_succ_out_degree   <= rd_ok_q ? avg_q[3] : '0;
            state_q                     <= S_IDLE;
          end
        end
        S_CLR: begin
          nidx_q <= nidx_q + ID_W'(1);
          if (nidx_q == n_m1) begin
            eidx_q  <= '0;
            state_q <= S_E1_RD;
          end
        end
        S_E1_RD: begin
          state_q <= S_E1_DEG;
        end
        S_E1_DEG: begin
          src_q   <= edge_src;
          dst_q   <= edge_dst;
          state_q <= S_E1_INC;
        end
        S_E1_INC: begin
          eidx_q <= eidx_q + ECW'(1);
          if (eidx_q == edge_total_q - ECW'(1)) begin
            nidx_q  <= '0;
            state_q <= S_N_RD;
          end else begin
            state_q <= S_E1_RD;
          end
        end
        S_N_RD: begin
          state_q <= S_N_ST;
        end
        S_N_ST: begin
          bi_q <= bin_of(in_rd, largest_q);
          bo_q <= bin_of(out_rd, largest_q);
          if ((32'(in_rd) >= 32'(largest_q)) || (32'(out_rd) >= 32'(largest_q))) begin
            sat_q <= 1'b1;
          end
          state_q <= S_N_WR;
        end
        S_N_WR: begin
          nidx_q <= nidx_q + ID_W'(1);
          if (nidx_q == n_m1) begin
            eidx_q  <= '0;
            state_q <= S_E2_RD;
          end else begin
            state_q <= S_N_RD;
          end
        end
        S_E2_RD: begin
          state_q <= S_E2_SRC;
        end
        S_E2_SRC: begin
          src_q   <= edge_src;
          dst_q   <= edge_dst;
          state_q <= S_E2_DST;
        end
        S_E2_DST: begin
          sin_q   <= in_rd;
          sout_q  <= out_rd;
          state_q <= S_E2_ST;
        end
        S_E2_ST: begin
          tin_q   <= in_rd;
          tout_q  <= out_rd;
          bi_q    <= bin_of(in_rd, largest_q);
          bo_q    <= bin_of(sout_q, largest_q);
          state_q <= S_E2_WR;
        end
        S_E2_WR: begin
          eidx_q <= eidx_q + ECW'(1);
          if (eidx_q == edge_total_q - ECW'(1)) begin
            state_q <= S_RESP;
          end else begin
            state_q <= S_E2_RD;
          end
        end
        S_R_RD: begin
          state_q <= S_R_LAT;
        end
        S_R_LAT: begin
          pred_q  <= pred_rd;
          succ_q  <= succ_rd;
          k_q     <= '0;
          state_q <= S_R_GO;
        end
        S_R_GO: begin
          if (sel_cnt == '0) begin
            avg_q[k_q] <= '0;
            k_q        <= k_q + 2'd1;
            if (k_q == 2'd3) begin
              state_q <= S_RESP;
            end
          end else begin
            state_q <= S_R_WAIT;
          end
        end
        S_R_WAIT: begin
          if (div_done) begin
            avg_q[k_q] <= div_avg;
            k_q        <= k_q + 2'd1;
            state_q    <= (k_q == 2'd3) ? S_RESP : S_R_GO;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  gdc_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES), .AW(EAW)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rd)
  );

  gdc_ram #(.WIDTH(DW), .DEPTH(MAX_NODES), .AW(NAW)) u_in_deg_ram (
    .clk_i   (clk_i),
    .we_i    (deg_we),
    .waddr_i (in_waddr),
    .wdata_i (in_wdata),
    .raddr_i (in_raddr),
    .rdata_o (in_rd)
  );

  gdc_ram #(.WIDTH(DW), .DEPTH(MAX_NODES), .AW(NAW)) u_out_deg_ram (
    .clk_i   (clk_i),
    .we_i    (deg_we),
    .waddr_i (out_waddr),
    .wdata_i (out_wdata),
    .raddr_i (out_raddr),
    .rdata_o (out_rd)
  );

  gdc_ram #(.WIDTH(RW), .DEPTH(MAX_NODES), .AW(NAW)) u_pred_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (pred_waddr),
    .wdata_i (pred_wdata),
    .raddr_i (pred_raddr),
    .rdata_o (pred_rd)
  );

  gdc_ram #(.WIDTH(RW), .DEPTH(MAX_NODES), .AW(NAW)) u_succ_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (succ_waddr),
    .wdata_i (succ_wdata),
    .raddr_i (succ_raddr),
    .rdata_o (succ_rd)
  );

  gdc_div #(.DVD_W(QW), .DVS_W(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (QW'(sel_sum) << FRAC_BITS),
    .divisor_i  (sel_cnt),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  a_edge_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(edge_total_q) <= MAX_EDGES)
    else $error("edge count beyond capacity");

  a_largest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(largest_q) <= MAX_NODES)
    else $error("node count beyond capacity");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_R_WAIT))
    else $error("divider finished outside a row read");

  a_finish_sets_computed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.mode == gdc_pkg::MODE_FINISH)) |=> computed_q)
    else $error("finish did not mark statistics computed");

endmodule
`default_nettype wire
